// ===== design/hrrn_pkg.sv =====
`default_nettype none
package hrrn_pkg;

	typedef enum logic [1:0] {
		CMD_ADMIT     = 2'd0,
		CMD_REQUEUE   = 2'd1,
		CMD_DISPATCH  = 2'd2,
		CMD_BURST_END = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_EMPTY       = 2'd2,
		ST_NOT_RUNNING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_POLICY   = 2'd0,
		REG_WEIGHT   = 2'd1,
		REG_INIT_EST = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADMIT,
		S_SCAN_MUL,
		S_SCAN_CMP,
		S_DISP_END,
		S_BURST_MUL,
		S_BURST_SUM
	} state_t;

	localparam int unsigned EST_W    = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned WEIGHT_W = 9;
	localparam int unsigned RATIO_W  = TIME_W + EST_W;
	localparam int unsigned OLD_W    = WEIGHT_W + EST_W;
	localparam int unsigned NEW_W    = WEIGHT_W + TIME_W;
	localparam int unsigned SUM_W    = NEW_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [EST_W-1:0]    EST_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [1:0]        command;
		logic [EST_W-1:0]  process_id;
		logic [EST_W-1:0]  estimate_in;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [EST_W-1:0] chosen_id;
		logic [EST_W-1:0] estimate_out;
	} result_t;

	typedef struct packed {
		logic [EST_W-1:0]  pid;
		logic [EST_W-1:0]  est;
		logic [TIME_W-1:0] ready_time;
		logic [TIME_W-1:0] order;
	} slot_t;

endpackage
`default_nettype wire

// ===== design/hrrn_ram.sv =====
`default_nettype none
module hrrn_ram #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire hrrn_pkg::slot_t          wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output hrrn_pkg::slot_t               rdata
);
	import hrrn_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/hrrn_ready_queue_scheduler.sv =====
// channel   direction  handshake                       payload
// command   in         start, busy                     item (item_t)
// result    out        done strobe, one cycle          result (result_t)
// config    in         cfg_valid, cfg_ready            cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low; done marks the result
// beat in the first cycle with busy low again, and the next command may start then.
// Admit and requeue keep busy through S_ADMIT; burst end through S_BURST_MUL and
// S_BURST_SUM (S_BURST_MUL alone when nothing runs). Dispatch scans all slots first:
// each slot takes a memory read, a multiply state and a compare with the running best.
// Reset empties the table and the running record; there is no clearing pass.
// The receiver cannot stall: a result beat is never held; config beats wait while busy.
`default_nettype none
module hrrn_ready_queue_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire hrrn_pkg::item_t   item,
	output logic                   done,
	output hrrn_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import hrrn_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t state_q, state_d;
	item_t item_q;
	logic [IDX_W-1:0] idx_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TIME_W-1:0] order_q;
	logic run_valid_q;
	logic [EST_W-1:0] run_pid_q, run_est_q;
	logic [TIME_W-1:0] run_start_q;
	logic policy_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [EST_W-1:0] init_est_q;
	logic done_q;
	result_t result_q;

	logic [TIME_W-1:0] cand_age_s1, cand_wait_s1;
	logic [EST_W-1:0] cand_e_s1, cand_pid_s1, cand_est_s1;
	logic [RATIO_W-1:0] lhs_s1, rhs_s1;

	logic best_valid_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [TIME_W-1:0] best_wait_q, best_age_q;
	logic [EST_W-1:0] best_e_q, best_pid_q, best_est_q;

	logic [OLD_W-1:0] prod_old_s1;
	logic [NEW_W-1:0] prod_new_s1;

	logic accept;
	logic mem_we;
	logic [IDX_W-1:0] mem_raddr;
	slot_t mem_wdata, rd;

	logic free_found;
	logic [IDX_W-1:0] free_idx;

	logic [TIME_W-1:0] wait_c, age_c, burst_c;
	logic [EST_W-1:0] e_c;
	logic better;
	logic [WEIGHT_W-1:0] a_c, inv_c;
	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-9:0] shr_c;
	logic [EST_W-1:0] new_est_c;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		mem_wdata.pid        = item_q.process_id;
		mem_wdata.est        = (item_q.command == CMD_ADMIT) ? init_est_q : item_q.estimate_in;
		mem_wdata.ready_time = item_q.now_ms;
		mem_wdata.order      = order_q;
	end

	hrrn_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(free_idx),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	always_comb begin
		wait_c  = item_q.now_ms - rd.ready_time;
		age_c   = order_q - rd.order;
		e_c     = (rd.est == '0) ? EST_W'(1) : rd.est;
		burst_c = item_q.now_ms - run_start_q;
		a_c     = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		inv_c   = WEIGHT_ONE - a_c;
		sum_c   = SUM_W'(prod_old_s1) + SUM_W'(prod_new_s1);
		shr_c   = sum_c[SUM_W-1:8];
		new_est_c = (|shr_c[SUM_W-9:EST_W]) ? EST_MAX : shr_c[EST_W-1:0];
		if (!best_valid_q) begin
			better = valid_q[idx_q];
		end else if (policy_q) begin
			better = valid_q[idx_q] && ((lhs_s1 > rhs_s1)
				|| (lhs_s1 == rhs_s1 && cand_age_s1 > best_age_q));
		end else begin
			better = valid_q[idx_q] && (cand_age_s1 > best_age_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.command)
						CMD_ADMIT, CMD_REQUEUE: state_d = S_ADMIT;
						CMD_DISPATCH: state_d = S_SCAN_MUL;
						default: state_d = S_BURST_MUL;
					endcase
				end
			end
			S_ADMIT: begin
				mem_we  = free_found;
				state_d = S_IDLE;
			end
			S_SCAN_MUL: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				mem_raddr = IDX_W'(idx_q + 1'b1);
				state_d   = (idx_q == LAST_IDX) ? S_DISP_END : S_SCAN_MUL;
			end
			S_DISP_END: begin
				state_d = S_IDLE;
			end
			S_BURST_MUL: begin
				state_d = run_valid_q ? S_BURST_SUM : S_IDLE;
			end
			S_BURST_SUM: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= 1'b0;
			weight_q   <= 9'd128;
			init_est_q <= 16'd10000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[0];
				REG_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_INIT_EST: init_est_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			order_q      <= '0;
			run_valid_q  <= 1'b0;
			run_pid_q    <= '0;
			run_est_q    <= '0;
			run_start_q  <= '0;
			done_q       <= 1'b0;
			best_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q        <= '0;
					best_valid_q <= 1'b0;
				end
				S_ADMIT: begin
					done_q <= 1'b1;
					if (free_found) begin
						valid_q[free_idx] <= 1'b1;
						order_q <= order_q + 1'b1;
					end
				end
				S_SCAN_CMP: begin
					if (better) begin
						best_valid_q <= 1'b1;
					end
					idx_q <= IDX_W'(idx_q + 1'b1);
				end
				S_DISP_END: begin
					done_q <= 1'b1;
					if (best_valid_q) begin
						valid_q[best_idx_q] <= 1'b0;
						run_valid_q <= 1'b1;
						run_pid_q   <= best_pid_q;
						run_est_q   <= best_est_q;
						run_start_q <= item_q.now_ms;
					end
				end
				S_BURST_MUL: begin
					if (!run_valid_q) begin
						done_q <= 1'b1;
					end
				end
				S_BURST_SUM: begin
					done_q      <= 1'b1;
					run_valid_q <= 1'b0;
					run_est_q   <= new_est_c;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		case (state_q)
			S_ADMIT: begin
				result_q <= result_t'{status: free_found ? ST_OK : ST_FULL,
					chosen_id: '0, estimate_out: '0};
			end
			S_SCAN_MUL: begin
				cand_wait_s1 <= wait_c;
				cand_age_s1  <= age_c;
				cand_e_s1    <= e_c;
				cand_pid_s1  <= rd.pid;
				cand_est_s1  <= rd.est;
				lhs_s1 <= RATIO_W'(wait_c) * RATIO_W'(best_e_q);
				rhs_s1 <= RATIO_W'(best_wait_q) * RATIO_W'(e_c);
			end
			S_SCAN_CMP: begin
				if (better) begin
					best_idx_q  <= idx_q;
					best_wait_q <= cand_wait_s1;
					best_age_q  <= cand_age_s1;
					best_e_q    <= cand_e_s1;
					best_pid_q  <= cand_pid_s1;
					best_est_q  <= cand_est_s1;
				end
			end
			S_DISP_END: begin
				if (best_valid_q) begin
					result_q <= result_t'{status: ST_OK, chosen_id: best_pid_q,
						estimate_out: best_est_q};
				end else begin
					result_q <= result_t'{status: ST_EMPTY, chosen_id: '0,
						estimate_out: '0};
				end
			end
			S_BURST_MUL: begin
				prod_old_s1 <= OLD_W'(a_c) * OLD_W'(run_est_q);
				prod_new_s1 <= NEW_W'(inv_c) * NEW_W'(burst_c);
				result_q <= result_t'{status: ST_NOT_RUNNING, chosen_id: '0,
					estimate_out: '0};
			end
			S_BURST_SUM: begin
				result_q <= result_t'{status: ST_OK, chosen_id: run_pid_q,
					estimate_out: new_est_c};
			end
			default: ;
		endcase
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a preceding busy cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command beat taken but block not busy");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (&$past(valid_q)))
		else $error("table full reported with a free slot");

	a_empty_means_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> ($past(valid_q) == '0))
		else $error("table empty reported with a valid slot");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import hrrn_pkg::*;

	localparam int DEPTH = 16;
	localparam int QUIET_LIMIT = 3000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t cmd_beat = '0;
	logic done;
	result_t result_beat;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	item_t pending_commands[$];
	result_t expected_results[$];
	reg_write_t reg_plan[$];
	int idle_pct = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	logic [31:0] now_cursor;

	// scheduler shadow state
	logic policy_hrrn;
	logic [8:0] weight;
	logic [15:0] init_est;
	logic slot_used[DEPTH];
	slot_t ready_table[DEPTH];
	logic [31:0] order_count;
	logic run_valid;
	logic [15:0] run_pid;
	logic [15:0] run_est;
	logic [31:0] run_start;

	int cmd_seen[4];
	int status_seen[4];
	int saturations = 0;
	int settings_run = 1;

	hrrn_ready_queue_scheduler #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cmd_beat),
		.done(done),
		.result(result_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void config_write(input logic [1:0] idx, input logic [15:0] data);
		case (idx)
			REG_POLICY:   policy_hrrn = data[0];
			REG_WEIGHT:   weight = data[8:0];
			REG_INIT_EST: init_est = data;
			default: ;
		endcase
	endfunction

	function automatic result_t schedule_step(input item_t beat);
		result_t r;
		int best;
		logic [31:0] age_i, age_b, wait_i, wait_b, burst;
		logic [15:0] e_i, e_b;
		logic [63:0] lhs, rhs, mix;
		logic [8:0] alpha;
		logic better;
		r = '0;
		best = -1;
		cmd_seen[beat.command]++;
		case (cmd_t'(beat.command))
			CMD_ADMIT, CMD_REQUEUE: begin
				for (int s = DEPTH - 1; s >= 0; s--)
					if (!slot_used[s])
						best = s;
				if (best < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_used[best] = 1'b1;
					ready_table[best].pid = beat.process_id;
					ready_table[best].est = (beat.command == CMD_ADMIT) ? init_est
						: beat.estimate_in;
					ready_table[best].ready_time = beat.now_ms;
					ready_table[best].order = order_count;
					order_count = order_count + 1;
				end
			end
			CMD_DISPATCH: begin
				for (int s = 0; s < DEPTH; s++) begin
					if (slot_used[s]) begin
						if (best < 0) begin
							best = s;
						end else begin
							age_i = order_count - ready_table[s].order;
							age_b = order_count - ready_table[best].order;
							if (policy_hrrn) begin
								e_i = (ready_table[s].est == 0) ? 16'd1 : ready_table[s].est;
								e_b = (ready_table[best].est == 0) ? 16'd1 : ready_table[best].est;
								wait_i = beat.now_ms - ready_table[s].ready_time;
								wait_b = beat.now_ms - ready_table[best].ready_time;
								lhs = 64'(wait_i) * 64'(e_b);
								rhs = 64'(wait_b) * 64'(e_i);
								better = (lhs > rhs) || (lhs == rhs && age_i > age_b);
							end else begin
								better = age_i > age_b;
							end
							if (better)
								best = s;
						end
					end
				end
				if (best < 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot_used[best] = 1'b0;
					run_valid = 1'b1;
					run_pid = ready_table[best].pid;
					run_est = ready_table[best].est;
					run_start = beat.now_ms;
					r.chosen_id = run_pid;
					r.estimate_out = run_est;
				end
			end
			default: begin
				if (!run_valid) begin
					r.status = ST_NOT_RUNNING;
				end else begin
					alpha = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
					burst = beat.now_ms - run_start;
					mix = (64'(alpha) * 64'(run_est)
						+ (64'(WEIGHT_ONE) - 64'(alpha)) * 64'(burst)) >> 8;
					if (mix > 64'(EST_MAX)) begin
						mix = 64'(EST_MAX);
						saturations++;
					end
					run_est = mix[15:0];
					run_valid = 1'b0;
					r.chosen_id = run_pid;
					r.estimate_out = mix[15:0];
				end
			end
		endcase
		status_seen[r.status]++;
		return r;
	endfunction

	function automatic item_t beat_of(input cmd_t c, input logic [15:0] pid,
			input logic [15:0] est, input logic [31:0] now);
		item_t b;
		b.command = c;
		b.process_id = pid;
		b.estimate_in = est;
		b.now_ms = now;
		return b;
	endfunction

	function automatic item_t random_beat(input cmd_t c);
		item_t b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			now_cursor = $urandom;
		else if (pick >= 30)
			now_cursor = now_cursor + $urandom_range(1, 400);
		b.command = c;
		b.process_id = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
		case ($urandom_range(3))
			0: b.estimate_in = 16'($urandom_range(2));
			1: b.estimate_in = 16'($urandom_range(3000));
			default: b.estimate_in = 16'($urandom);
		endcase
		b.now_ms = now_cursor;
		return b;
	endfunction

	// runs of fill, drain and mixed traffic keep the table swinging between full and empty
	task automatic queue_random_beats(input int count);
		int run_left, run_kind, r;
		item_t b;
		run_left = 0;
		run_kind = 0;
		repeat (count) begin
			if (run_left == 0) begin
				run_kind = $urandom_range(2);
				run_left = $urandom_range(4, 24);
			end
			run_left--;
			r = $urandom_range(99);
			if (r < 5) begin
				b = random_beat(cmd_t'($urandom_range(3)));
				b.now_ms = $urandom;
			end else begin
				r = $urandom_range(99);
				case (run_kind)
					0: b = random_beat(r < 70 ? (r[0] ? CMD_ADMIT : CMD_REQUEUE)
						: r < 85 ? CMD_DISPATCH : CMD_BURST_END);
					1: b = random_beat(r < 20 ? (r[0] ? CMD_ADMIT : CMD_REQUEUE)
						: r < 75 ? CMD_DISPATCH : CMD_BURST_END);
					default: b = random_beat(r < 35 ? (r[0] ? CMD_ADMIT : CMD_REQUEUE)
						: r < 70 ? CMD_DISPATCH : CMD_BURST_END);
				endcase
			end
			pending_commands.push_back(b);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_commands.size() != 0 || start || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_reg_writes();
		int k;
		k = 0;
		cfg_valid <= 1'b1;
		cfg_index <= reg_plan[0].index;
		cfg_data <= reg_plan[0].data;
		while (k < reg_plan.size()) begin
			@(posedge clk);
			if (cfg_ready) begin
				config_write(cfg_index, cfg_data);
				k++;
				if (k < reg_plan.size()) begin
					cfg_index <= reg_plan[k].index;
					cfg_data <= reg_plan[k].data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
		reg_plan.delete();
	endtask

	task automatic run_setting(input logic policy, input logic [8:0] w, input logic [15:0] init,
			input logic poke_unused, input int count, input int idle);
		wait_drained();
		reg_plan.push_back('{REG_POLICY, {15'($urandom), policy}});
		reg_plan.push_back('{REG_WEIGHT, {7'($urandom), w}});
		reg_plan.push_back('{REG_INIT_EST, init});
		if (poke_unused)
			reg_plan.push_back('{REG_UNUSED, 16'hFFFF});
		apply_reg_writes();
		settings_run++;
		idle_pct = idle;
		queue_random_beats(count);
	endtask

	// drive: hold a presented beat until taken, then maybe idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(schedule_step(cmd_beat));
			if (!start || !busy) begin
				if (pending_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					cmd_beat <= pending_commands.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d id %0h estimate %0d",
					result_beat.status, result_beat.chosen_id, result_beat.estimate_out);
				mismatches++;
			end else begin
				result_t want;
				want = expected_results.pop_front();
				if (result_beat.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_beat.status);
					mismatches++;
				end
				if (result_beat.chosen_id !== want.chosen_id) begin
					$error("chosen_id: expected %0h, got %0h", want.chosen_id,
						result_beat.chosen_id);
					mismatches++;
				end
				if (result_beat.estimate_out !== want.estimate_out) begin
					$error("estimate_out: expected %0d, got %0d", want.estimate_out,
						result_beat.estimate_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL hrrn_ready_queue_scheduler");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		policy_hrrn = 1'b0;
		weight = 9'd128;
		init_est = 16'd10000;
		order_count = '0;
		run_valid = 1'b0;
		run_pid = '0;
		run_est = '0;
		run_start = '0;
		for (int s = 0; s < DEPTH; s++) begin
			slot_used[s] = 1'b0;
			ready_table[s] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			cmd_seen[k] = 0;
			status_seen[k] = 0;
		end
		now_cursor = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		pending_commands.push_back(beat_of(CMD_BURST_END, 16'h0000, 16'h0000, 32'h0));
		pending_commands.push_back(beat_of(CMD_DISPATCH, 16'h0000, 16'h0000, 32'h0));
		pending_commands.push_back(beat_of(CMD_ADMIT, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0));
		pending_commands.push_back(beat_of(CMD_REQUEUE, 16'h0000, 16'h0000, 32'hFFFF_FFF8));
		pending_commands.push_back(beat_of(CMD_REQUEUE, 16'hFFFF, 16'hFFFF, 32'd5));
		pending_commands.push_back(beat_of(CMD_DISPATCH, 16'h0000, 16'h0000, 32'd10));
		pending_commands.push_back(beat_of(CMD_DISPATCH, 16'h0000, 16'h0000, 32'd20));
		pending_commands.push_back(beat_of(CMD_BURST_END, 16'h0000, 16'h0000, 32'hFFFF_0000));
		pending_commands.push_back(beat_of(CMD_BURST_END, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
		for (int k = 0; k < 16; k++)
			pending_commands.push_back(beat_of(CMD_ADMIT, 16'(k * 16'h1111), 16'(k),
				32'd100 + k));

		run_setting(1'b1, 9'd0, 16'd0, 1'b0, 200, 0);
		run_setting(1'b0, 9'd256, 16'hFFFF, 1'b0, 200, 64);
		run_setting(1'b1, 9'd511, 16'd1, 1'b0, 200, 0);
		run_setting(1'b1, 9'd128, 16'd10000, 1'b1, 200, 21);
		for (int p = 0; p < 4; p++)
			run_setting(1'($urandom), 9'($urandom), 16'($urandom), 1'b0, 200,
				(p % 2 == 0) ? 64 : 21);

		wait_drained();
		repeat (2 * DEPTH + 8) @(posedge clk);
		$display("ran %0d admits, %0d requeues, %0d dispatches, %0d burst ends under %0d settings",
			cmd_seen[CMD_ADMIT], cmd_seen[CMD_REQUEUE], cmd_seen[CMD_DISPATCH],
			cmd_seen[CMD_BURST_END], settings_run);
		$display("table full %0d, table empty %0d, nothing running %0d, saturated estimates %0d",
			status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOT_RUNNING],
			saturations);
		if (mismatches == 0)
			$display("PASS hrrn_ready_queue_scheduler");
		else
			$display("FAIL hrrn_ready_queue_scheduler");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hrrn_pkg.sv
design/hrrn_ram.sv
design/hrrn_ready_queue_scheduler.sv
bench/testbench.sv
